[design/gshb_pkg.sv]
// ----------------------------------------------------------------------------
// gshb_pkg
// Types and codes shared by the gossip heartbeat failure detector.
// ----------------------------------------------------------------------------
package gshb_pkg;

    // Operation codes of a command.
    localparam logic [1:0] OP_JOIN  = 2'd0;
    localparam logic [1:0] OP_MERGE = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;
    localparam logic [1:0] OP_RSVD  = 2'd3;

    // Member status codes.
    localparam logic [1:0] ST_ALIVE = 2'd0;
    localparam logic [1:0] ST_SUSP  = 2'd1;
    localparam logic [1:0] ST_GONE  = 2'd2;
    localparam logic [1:0] ST_RSVD  = 2'd3;

    // Result kinds.
    localparam logic [2:0] K_ADDED   = 3'd0;
    localparam logic [2:0] K_UPDATED = 3'd1;
    localparam logic [2:0] K_IGNORED = 3'd2;
    localparam logic [2:0] K_FULL    = 3'd3;
    localparam logic [2:0] K_REMOVED = 3'd4;
    localparam logic [2:0] K_TARGET  = 3'd5;
    localparam logic [2:0] K_NONE    = 3'd6;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SELF_ID    = 2'd0;
    localparam logic [1:0] CFG_FAIL_TMO   = 2'd1;
    localparam logic [1:0] CFG_CLEAN_TMO  = 2'd2;
    localparam logic [1:0] CFG_GROUP_SIZE = 2'd3;

    // Removal reports per tick are capped at this count.
    localparam logic [3:0] MAX_REMOVED = 4'd15;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] member_id;
        logic [31:0] beat_count;
        logic [1:0]  entry_status;
        logic [31:0] now;
        logic [7:0]  pick;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] out_id;
        logic [3:0]  slot;
        logic        last;
    } result_t;

endpackage

[design/gossip_heartbeat_failure_detector.sv]
// ----------------------------------------------------------------------------
// gossip_heartbeat_failure_detector
// Membership table with join, merge and tick operations of a gossip-style
// heartbeat failure detector.
// ----------------------------------------------------------------------------
// Usage: a command is taken when start is high and busy is low. The block
// then stays busy while a small sequencer walks the table one slot per cycle
// through a single shared compare path. Each result appears on result for one
// cycle with result_valid high; the receiver cannot stall, so no result is
// ever held. The final result of a command has last set, and busy drops in
// that same cycle, so the next command may start right away.
// A tick runs through find self, age pass, an 8-step remainder unit for the
// target number and target scan. Removal reports come out during the age
// pass, one per cycle. Configuration writes use cfg_valid/cfg_ready and are
// always ready; they are meant to happen while the block is idle.
// Reset empties the table and loads the configuration defaults.
module gossip_heartbeat_failure_detector #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  gshb_pkg::cmd_t    cmd,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    output logic              result_valid,
    output gshb_pkg::result_t result
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_JOIN,
        S_MSCAN,
        S_TFIND,
        S_TAGE,
        S_TDIV,
        S_TSCAN
    } state_t;

    state_t            state_reg, state_next;
    gshb_pkg::cmd_t    cmd_reg, cmd_next;
    logic [CNT_W-1:0]  used_reg, used_next;
    logic [CNT_W-1:0]  scan_reg, scan_next;
    logic [3:0]        removed_reg, removed_next;
    logic [7:0]        rem_reg, rem_next;
    logic [7:0]        quo_reg, quo_next;
    logic [2:0]        step_reg, step_next;
    logic [31:0]       target_reg, target_next;
    logic              res_valid_reg, res_valid_next;
    gshb_pkg::result_t result_reg, result_next;

    logic [31:0] self_id_reg, fail_tmo_reg, clean_tmo_reg;
    logic [7:0]  group_size_reg;

    logic [31:0] ids_reg    [TABLE_DEPTH];
    logic [31:0] beats_reg  [TABLE_DEPTH];
    logic [31:0] stamps_reg [TABLE_DEPTH];
    logic [1:0]  status_reg [TABLE_DEPTH];

    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [31:0]      wr_id, wr_beat, wr_stamp;
    logic [1:0]       wr_status;

    logic [IDX_W-1:0] rd_idx;
    logic [31:0]      cur_id, cur_beat, cur_stamp, age;
    logic [1:0]       cur_status;
    logic             in_range, id_is_self;
    logic [CNT_W+3:0] scan_ext, used_ext;
    logic [3:0]       scan_slot, used_slot;
    logic [8:0]       divisor, trial;

    assign rd_idx     = scan_reg[IDX_W-1:0];
    assign cur_id     = ids_reg[rd_idx];
    assign cur_beat   = beats_reg[rd_idx];
    assign cur_stamp  = stamps_reg[rd_idx];
    assign cur_status = status_reg[rd_idx];
    assign in_range   = scan_reg < used_reg;
    assign id_is_self = cur_id == self_id_reg;
    assign age        = cmd_reg.now - cur_stamp;
    assign scan_ext   = {4'b0000, scan_reg};
    assign used_ext   = {4'b0000, used_reg};
    assign scan_slot  = scan_ext[3:0];
    assign used_slot  = used_ext[3:0];
    // A group size of zero stands for 256.
    assign divisor    = (group_size_reg == 8'd0) ? 9'd256 : {1'b0, group_size_reg};
    assign trial      = {rem_reg, quo_reg[7]};

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        used_next      = used_reg;
        scan_next      = scan_reg;
        removed_next   = removed_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        step_next      = step_reg;
        target_next    = target_reg;
        res_valid_next = 1'b0;
        result_next    = result_reg;
        wr_en          = 1'b0;
        wr_idx         = rd_idx;
        wr_id          = cur_id;
        wr_beat        = cur_beat;
        wr_stamp       = cur_stamp;
        wr_status      = cur_status;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next  = cmd;
                    scan_next = '0;
                    case (cmd.opcode)
                        gshb_pkg::OP_JOIN:
                        begin
                            if (cmd.member_id == 32'd0)
                            begin
                                res_valid_next = 1'b1;
                                result_next    = '{gshb_pkg::K_IGNORED, 32'd0, 4'd0, 1'b1};
                            end
                            else
                            begin
                                state_next = S_JOIN;
                                if (used_reg == '0)
                                begin
                                    wr_en          = 1'b1;
                                    wr_idx         = '0;
                                    wr_id          = self_id_reg;
                                    wr_beat        = 32'd1;
                                    wr_stamp       = cmd.now;
                                    wr_status      = gshb_pkg::ST_ALIVE;
                                    used_next      = CNT_W'(1);
                                    res_valid_next = 1'b1;
                                    result_next    = '{gshb_pkg::K_ADDED, self_id_reg,
                                                       4'd0, 1'b0};
                                end
                            end
                        end
                        gshb_pkg::OP_MERGE:
                        begin
                            if (cmd.member_id == 32'd0 || cmd.entry_status >= gshb_pkg::ST_GONE)
                            begin
                                res_valid_next = 1'b1;
                                result_next    = '{gshb_pkg::K_IGNORED, cmd.member_id,
                                                   4'd0, 1'b1};
                            end
                            else
                            begin
                                state_next = S_MSCAN;
                            end
                        end
                        gshb_pkg::OP_TICK:
                        begin
                            state_next = S_TFIND;
                        end
                        default:
                        begin
                            res_valid_next = 1'b1;
                            result_next    = '{gshb_pkg::K_IGNORED, cmd.member_id, 4'd0, 1'b1};
                        end
                    endcase
                end
            end

            S_JOIN:
            begin
                state_next     = S_IDLE;
                res_valid_next = 1'b1;
                if (used_reg >= DEPTH_C)
                begin
                    result_next = '{gshb_pkg::K_FULL, cmd_reg.member_id, 4'd0, 1'b1};
                end
                else
                begin
                    wr_en       = 1'b1;
                    wr_idx      = used_reg[IDX_W-1:0];
                    wr_id       = cmd_reg.member_id;
                    wr_beat     = 32'd1;
                    wr_stamp    = cmd_reg.now;
                    wr_status   = gshb_pkg::ST_ALIVE;
                    used_next   = used_reg + CNT_W'(1);
                    result_next = '{gshb_pkg::K_ADDED, cmd_reg.member_id, used_slot, 1'b1};
                end
            end

            S_MSCAN:
            begin
                if (in_range && cur_id == cmd_reg.member_id)
                begin
                    wr_en     = 1'b1;
                    wr_status = cmd_reg.entry_status;
                    if (cur_beat < cmd_reg.beat_count)
                    begin
                        wr_beat  = cmd_reg.beat_count;
                        wr_stamp = cmd_reg.now;
                    end
                    state_next     = S_IDLE;
                    res_valid_next = 1'b1;
                    result_next    = '{gshb_pkg::K_UPDATED, cmd_reg.member_id, scan_slot, 1'b1};
                end
                else if (in_range)
                begin
                    scan_next = scan_reg + CNT_W'(1);
                end
                else
                begin
                    state_next     = S_IDLE;
                    res_valid_next = 1'b1;
                    if (used_reg >= DEPTH_C)
                    begin
                        result_next = '{gshb_pkg::K_FULL, cmd_reg.member_id, 4'd0, 1'b1};
                    end
                    else
                    begin
                        wr_en       = 1'b1;
                        wr_idx      = used_reg[IDX_W-1:0];
                        wr_id       = cmd_reg.member_id;
                        wr_beat     = cmd_reg.beat_count;
                        wr_stamp    = cmd_reg.now;
                        wr_status   = cmd_reg.entry_status;
                        used_next   = used_reg + CNT_W'(1);
                        result_next = '{gshb_pkg::K_ADDED, cmd_reg.member_id, used_slot, 1'b1};
                    end
                end
            end

            S_TFIND:
            begin
                if (in_range && id_is_self && cur_status == gshb_pkg::ST_ALIVE)
                begin
                    state_next   = S_TAGE;
                    scan_next    = '0;
                    removed_next = '0;
                end
                else if (in_range && !id_is_self)
                begin
                    scan_next = scan_reg + CNT_W'(1);
                end
                else
                begin
                    // Own id missing or its first entry not alive.
                    state_next     = S_IDLE;
                    res_valid_next = 1'b1;
                    result_next    = '{gshb_pkg::K_NONE, 32'd0, 4'd0, 1'b1};
                end
            end

            S_TAGE:
            begin
                if (in_range)
                begin
                    scan_next = scan_reg + CNT_W'(1);
                    if (id_is_self)
                    begin
                        wr_en     = 1'b1;
                        wr_status = gshb_pkg::ST_ALIVE;
                        wr_beat   = cur_beat + 32'd1;
                        wr_stamp  = cmd_reg.now;
                    end
                    else if (cur_status == gshb_pkg::ST_ALIVE)
                    begin
                        if (age > fail_tmo_reg)
                        begin
                            wr_en     = 1'b1;
                            wr_status = gshb_pkg::ST_SUSP;
                        end
                    end
                    else if (cur_status == gshb_pkg::ST_SUSP)
                    begin
                        if (age > clean_tmo_reg)
                        begin
                            wr_en     = 1'b1;
                            wr_status = gshb_pkg::ST_GONE;
                            wr_beat   = 32'd0;
                            wr_stamp  = 32'd0;
                            if (removed_reg < gshb_pkg::MAX_REMOVED)
                            begin
                                removed_next   = removed_reg + 4'd1;
                                res_valid_next = 1'b1;
                                result_next    = '{gshb_pkg::K_REMOVED, cur_id, scan_slot, 1'b0};
                            end
                        end
                    end
                end
                else
                begin
                    state_next = S_TDIV;
                    rem_next   = 8'd0;
                    quo_next   = cmd_reg.pick;
                    step_next  = 3'd0;
                end
            end

            S_TDIV:
            begin
                // Restoring remainder, one pick bit per cycle, MSB first.
                quo_next  = {quo_reg[6:0], 1'b0};
                step_next = step_reg + 3'd1;
                if (trial >= divisor)
                begin
                    rem_next = 8'(trial - divisor);
                end
                else
                begin
                    rem_next = trial[7:0];
                end
                if (step_reg == 3'd7)
                begin
                    state_next  = S_TSCAN;
                    scan_next   = '0;
                    target_next = {24'd0, rem_next} + 32'd1;
                end
            end

            S_TSCAN:
            begin
                if (in_range && cur_status != gshb_pkg::ST_GONE && !id_is_self
                    && cur_id == target_reg)
                begin
                    state_next     = S_IDLE;
                    res_valid_next = 1'b1;
                    result_next    = '{gshb_pkg::K_TARGET, cur_id, scan_slot, 1'b1};
                end
                else if (in_range)
                begin
                    scan_next = scan_reg + CNT_W'(1);
                end
                else
                begin
                    state_next     = S_IDLE;
                    res_valid_next = 1'b1;
                    result_next    = '{gshb_pkg::K_NONE, target_reg, 4'd0, 1'b1};
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            used_reg       <= '0;
            scan_reg       <= '0;
            removed_reg    <= '0;
            step_reg       <= '0;
            res_valid_reg  <= 1'b0;
            self_id_reg    <= 32'd1;
            fail_tmo_reg   <= 32'd5;
            clean_tmo_reg  <= 32'd20;
            group_size_reg <= 8'd10;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            scan_reg      <= scan_next;
            removed_reg   <= removed_next;
            step_reg      <= step_next;
            res_valid_reg <= res_valid_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    gshb_pkg::CFG_SELF_ID:    self_id_reg    <= cfg_data;
                    gshb_pkg::CFG_FAIL_TMO:   fail_tmo_reg   <= cfg_data;
                    gshb_pkg::CFG_CLEAN_TMO:  clean_tmo_reg  <= cfg_data;
                    gshb_pkg::CFG_GROUP_SIZE: group_size_reg <= cfg_data[7:0];
                    default:                  ;
                endcase
            end
        end
    end

    // Payload registers and the table itself need no reset: only slots below
    // the fill count are ever read.
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        target_reg <= target_next;
        result_reg <= result_next;
        if (wr_en)
        begin
            ids_reg[wr_idx]    <= wr_id;
            beats_reg[wr_idx]  <= wr_beat;
            stamps_reg[wr_idx] <= wr_stamp;
            status_reg[wr_idx] <= wr_status;
        end
    end

    assign busy         = state_reg != S_IDLE;
    assign cfg_ready    = 1'b1;
    assign result_valid = res_valid_reg;
    assign result       = result_reg;

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= DEPTH_C)
        else $error("fill count beyond table depth");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy) || $past(start))
        else $error("result without a command in progress");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last |-> !busy)
        else $error("sequencer still busy after final result");

    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |-> busy)
        else $error("sequencer idle before final result");

endmodule
